/* rtl/core/bbn_pkg.sv */
`timescale 1ns / 1ps
package bbn_pkg;
	typedef struct packed {
		logic [31:0] coord_x;
		logic [31:0] coord_y;
		logic [31:0] coord_z;
		logic        last_vertex;
	} bbn_in_t;

	typedef struct packed {
		logic [31:0] scale_factor;
		logic [31:0] offset_x;
		logic [31:0] offset_y;
		logic [31:0] offset_z;
		logic        degenerate;
	} bbn_out_t;

	localparam int SqrtSteps = 35;
	localparam int DivSteps  = 34;

	typedef struct packed {
		logic fold;
		logic sq_load;
		logic sq_step;
		logic sum_load;
		logic rt_load;
		logic rt_step;
		logic dv_load;
		logic dv_step;
		logic off_load;
		logic [1:0] off_axis;
		logic clear;
	} bbn_cmd_t;
endpackage

/* rtl/core/bbn_datapath.sv */
`timescale 1ns / 1ps
module bbn_datapath import bbn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  bbn_in_t  vin,
	input  bbn_cmd_t cmd,
	output bbn_out_t res
);
	logic [31:0] lo_q [3];
	logic [31:0] hi_q [3];
	logic        seen_q;
	logic [31:0] sz_q [3];
	logic [63:0] sq_q [3];
	logic [67:0] sum_q;
	logic [67:0] rem_q;
	logic [34:0] root_q;
	logic [5:0]  rbit_q;
	logic [33:0] num_q;
	logic [35:0] drem_q;
	logic [33:0] quo_q;
	logic [31:0] scale_q;
	logic [31:0] off_q [3];
	logic        degen_q;
	logic [31:0] vin_c [3];
	logic [1:0]  ax;

	assign vin_c[0] = vin.coord_x;
	assign vin_c[1] = vin.coord_y;
	assign vin_c[2] = vin.coord_z;

	// offset beats 1..3 handle axes x..z
	assign ax = (cmd.off_axis == 2'd0) ? 2'd0 : cmd.off_axis - 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			seen_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
			end
		end else if (cmd.fold) begin
			seen_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				if (!seen_q || $signed(vin_c[i]) < $signed(lo_q[i])) lo_q[i] <= vin_c[i];
				if (!seen_q || $signed(vin_c[i]) > $signed(hi_q[i])) hi_q[i] <= vin_c[i];
			end
		end
	end

	// root trial: (2r+bit)*bit vs remainder, restoring
	logic [69:0] trial;
	logic [69:0] rshift;
	always_comb begin
		rshift = {35'd0, root_q} << (rbit_q + 6'd1);
		trial  = rshift | (70'd1 << {rbit_q, 1'b0});
	end

	logic [35:0] dtrial;
	logic [34:0] dsub;
	always_comb begin
		dtrial = {drem_q[34:0], num_q[33]};
		dsub   = 35'(dtrial) - {root_q};
	end

	// offset: 33-bit |c| times scale
	logic [32:0] c_s;
	logic [32:0] mag;
	logic [64:0] prod;
	logic [47:0] m;
	logic [31:0] offv;
	always_comb begin
		c_s  = {lo_q[ax][31], lo_q[ax]}
		     + {hi_q[ax][31], hi_q[ax]};
		mag  = c_s[32] ? (33'd0 - c_s) : c_s;
		prod = 65'(mag) * 65'(scale_q);
		m    = prod[64:17];
		if (c_s[32] || c_s == '0)
			offv = (m > 48'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
		else
			offv = (m > 48'h80000000) ? 32'h80000000 : (32'd0 - m[31:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			for (int i = 0; i < 3; i++) sz_q[i] <= hi_q[i] - lo_q[i];
		end
		if (cmd.sq_step) begin
			for (int i = 0; i < 3; i++) sq_q[i] <= 64'(sz_q[i]) * 64'(sz_q[i]);
		end
		if (cmd.sum_load) sum_q <= 68'(sq_q[0]) + 68'(sq_q[1]) + 68'(sq_q[2]);
		if (cmd.rt_load) begin
			rem_q  <= sum_q;
			root_q <= '0;
			rbit_q <= 6'(SqrtSteps - 1);
		end else if (cmd.rt_step) begin
			if ({2'b0, rem_q} >= trial) begin
				rem_q  <= 68'({2'b0, rem_q} - trial);
				root_q <= root_q | (35'd1 << rbit_q);
			end
			rbit_q <= rbit_q - 6'd1;
		end
		if (cmd.dv_load) begin
			num_q  <= 34'h200000000;
			drem_q <= '0;
			quo_q  <= '0;
		end else if (cmd.dv_step) begin
			num_q <= {num_q[32:0], 1'b0};
			if (root_q != '0 && dtrial >= {1'b0, root_q}) begin
				drem_q <= {1'b0, dsub};
				quo_q  <= {quo_q[32:0], 1'b1};
			end else begin
				drem_q <= dtrial;
				quo_q  <= {quo_q[32:0], 1'b0};
			end
		end
		if (cmd.off_load && cmd.off_axis == 2'd0) begin
			degen_q <= (root_q == '0);
			scale_q <= (root_q == '0 || quo_q[33:32] != 2'b0) ? 32'hFFFFFFFF : quo_q[31:0];
		end
		if (cmd.off_load && cmd.off_axis != 2'd0) off_q[cmd.off_axis - 2'd1] <= offv;
		if (cmd.clear) off_q[2] <= offv;
	end

	assign res.scale_factor = scale_q;
	assign res.offset_x     = off_q[0];
	assign res.offset_y     = off_q[1];
	assign res.offset_z     = off_q[2];
	assign res.degenerate   = degen_q;
endmodule

/* rtl/core/bbn_ctrl.sv */
`timescale 1ns / 1ps
module bbn_ctrl import bbn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     last_vertex,
	output logic     busy,
	output logic     done,
	output bbn_cmd_t cmd
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StSq   = 3'd1;
	localparam logic [2:0] StSum  = 3'd2;
	localparam logic [2:0] StRoot = 3'd3;
	localparam logic [2:0] StDiv  = 3'd4;
	localparam logic [2:0] StOff  = 3'd5;
	localparam logic [2:0] StSize = 3'd6;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic       done_q;
	logic       acc;

	assign acc  = start && state_q == StIdle;
	assign busy = state_q != StIdle;
	assign done = done_q;

	always_comb begin
		cmd          = '0;
		cmd.fold     = acc;
		cmd.off_axis = cnt_q[1:0];
		case (state_q)
			StSize: cmd.sq_load = 1'b1;
			StSq:   cmd.sq_step = 1'b1;
			StSum:  begin
				cmd.sum_load = 1'b1;
			end
			StRoot: begin
				cmd.rt_load = cnt_q == 6'd0 && !cmd.sum_load;
				cmd.rt_step = cnt_q != 6'd0;
				cmd.dv_load = cnt_q == 6'(SqrtSteps);
			end
			StDiv:  cmd.dv_step = 1'b1;
			StOff:  begin
				cmd.off_load = cnt_q != 6'd3;
				cmd.clear    = cnt_q == 6'd3;
			end
			default: cmd.clear = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				StIdle: if (acc && last_vertex) state_q <= StSize;
				StSize: state_q <= StSq;
				StSq:   state_q <= StSum;
				StSum:  begin
					state_q <= StRoot;
					cnt_q   <= '0;
				end
				StRoot: begin
					if (cnt_q == 6'(SqrtSteps)) begin
						state_q <= StDiv;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 6'd1;
				end
				StDiv: begin
					if (cnt_q == 6'(DivSteps - 1)) begin
						state_q <= StOff;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 6'd1;
				end
				StOff: begin
					if (cnt_q == 6'd3) begin
						state_q <= StIdle;
						cnt_q   <= '0;
						done_q  <= 1'b1;
					end else cnt_q <= cnt_q + 6'd1;
				end
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule

/* rtl/core/bounding_box_normalize_top.sv */
`timescale 1ns / 1ps
// Non-last vertex beat: a new vertex may be taken every cycle while busy is low.
// Last vertex: busy through the size, square, sum, root, divide and offset states;
// done strobes the result in the same cycle that busy drops.
// The receiver cannot stall.
// Reset (arst_n low, async) clears the box and controller.
module bounding_box_normalize_top import bbn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  bbn_in_t  vin,
	output logic     busy,
	output logic     done,
	output bbn_out_t result
);
	bbn_cmd_t cmd;

	bbn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_vertex(vin.last_vertex),
		.busy(busy), .done(done), .cmd(cmd)
	);

	bbn_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .vin(vin), .cmd(cmd), .res(result)
	);
endmodule
